// ===== sv/mie_pkg.sv =====
// Package for the I-type execute block: opcodes, status codes, register
// indexes and the queue entry type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mie_pkg;
  localparam int unsigned MemWords = 16384;
  localparam int unsigned MemAw = $clog2(MemWords);
  localparam logic [31:0] IoAddr = 32'h3000_0000;
  localparam logic [31:0] SignBit = 32'h8000_0000;

  localparam logic [1:0] CfgDataBase = 2'd0;
  localparam logic [1:0] CfgDataBytes = 2'd1;
  localparam logic [1:0] CfgBootAddr = 2'd2;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StIoRead = 3'd1;
  localparam logic [2:0] StIoWrite = 3'd2;
  localparam logic [2:0] StInvalid = 3'd3;
  localparam logic [2:0] StOverflow = 3'd4;
  localparam logic [2:0] StRange = 3'd5;

  localparam logic [5:0] OpRegimm = 6'h01;
  localparam logic [5:0] OpBeq = 6'h04;
  localparam logic [5:0] OpBne = 6'h05;
  localparam logic [5:0] OpBlez = 6'h06;
  localparam logic [5:0] OpBgtz = 6'h07;
  localparam logic [5:0] OpAddi = 6'h08;
  localparam logic [5:0] OpAddiu = 6'h09;
  localparam logic [5:0] OpSlti = 6'h0A;
  localparam logic [5:0] OpSltiu = 6'h0B;
  localparam logic [5:0] OpAndi = 6'h0C;
  localparam logic [5:0] OpOri = 6'h0D;
  localparam logic [5:0] OpXori = 6'h0E;
  localparam logic [5:0] OpLui = 6'h0F;
  localparam logic [5:0] OpLb = 6'h20;
  localparam logic [5:0] OpLh = 6'h21;
  localparam logic [5:0] OpLwl = 6'h22;
  localparam logic [5:0] OpLw = 6'h23;
  localparam logic [5:0] OpLbu = 6'h24;
  localparam logic [5:0] OpLhu = 6'h25;
  localparam logic [5:0] OpLwr = 6'h26;
  localparam logic [5:0] OpSb = 6'h28;
  localparam logic [5:0] OpSh = 6'h29;
  localparam logic [5:0] OpSw = 6'h2B;

  typedef enum logic [1:0] {
    BkIdle = 2'd0,
    BkRead = 2'd1,
    BkDone = 2'd2
  } bk_state_e;

  // Decoded instruction handed from front to back.
  typedef struct packed {
    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [15:0] imm;
    logic        is_mem;
  } dec_t;
endpackage
`default_nettype wire

// ===== sv/mie_if.sv =====
// Valid/ready channel interfaces for instructions, results and config writes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface mie_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;
  modport source (output valid, instruction_word, input ready);
  modport sink (input valid, instruction_word, output ready);
endinterface

interface mie_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] next_pc;
  logic        reg_written;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic [31:0] io_data;
  modport source (output valid, status, next_pc, reg_written, reg_index, reg_value,
                  io_data, input ready);
  modport sink (input valid, status, next_pc, reg_written, reg_index, reg_value,
                io_data, output ready);
endinterface

interface mie_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/mie_front.sv =====
// Front end: accepts instruction words, splits the fields and queues them
// in a two-entry FIFO for the back end. Depends on mie_pkg and mie_if.
`timescale 1ns / 1ps
`default_nettype none
module mie_front (
  input  wire             clk_i,
  input  wire             rst_ni,
  mie_instr_if.sink       in_if,
  output logic            deq_valid_o,
  input  wire             deq_ready_i,
  output mie_pkg::dec_t   deq_o
);
  import mie_pkg::*;

  dec_t       fifo_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  dec_t       dec;

  always_comb begin
    dec.op = in_if.instruction_word[31:26];
    dec.rs = in_if.instruction_word[25:21];
    dec.rt = in_if.instruction_word[20:16];
    dec.imm = in_if.instruction_word[15:0];
    dec.is_mem = in_if.instruction_word[31];
  end

  assign in_if.ready = (cnt_q != 2'd2);
  assign push = in_if.valid && in_if.ready;
  assign deq_valid_o = (cnt_q != 2'd0);
  assign pop = deq_valid_o && deq_ready_i;
  assign deq_o = fifo_q[rptr_q];
  assign wptr_d = wptr_q ^ push;
  assign rptr_d = rptr_q ^ pop;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
    else $error("full queue lost an entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("push did not raise count");
endmodule
`default_nettype wire

// ===== sv/mie_back.sv =====
// Back end: register file, data memory, PC and result register. Executes one
// queued instruction at a time, then the next. Depends on mie_pkg and mie_if.
`timescale 1ns / 1ps
`default_nettype none
module mie_back (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             deq_valid_i,
  output logic            deq_ready_o,
  input  mie_pkg::dec_t   deq_i,
  mie_cfg_if.sink         cfg_if,
  mie_result_if.source    out_if
);
  import mie_pkg::*;

  logic [31:0] mem_q [MemWords];
  logic [31:0] regs_q [32];
  logic [31:0] data_base_q, pc_q;
  logic [16:0] data_bytes_q;
  logic [MemAw:0] clr_cnt_q;
  logic        clearing;
  bk_state_e   st_q, st_d;
  dec_t        cur_q;
  logic [31:0] a_q, b_q;
  logic [31:0] rd0_q, rd1_q;
  logic        out_valid_q;
  logic [2:0]  o_status_q;
  logic [31:0] o_npc_q, o_val_q, o_io_q;
  logic        o_wr_q;
  logic [4:0]  o_idx_q;

  // Address work, from registered operands.
  logic [31:0] simm, addr, off, start, nbytes, target;
  logic [32:0] endb;
  logic [17:0] wsize;
  logic [1:0]  k;
  logic [MemAw-1:0] w0, w1;
  logic [63:0] pair, shifted;
  logic [31:0] v;
  logic        is_store, range_bad;

  assign clearing = !clr_cnt_q[MemAw];
  assign simm = {{16{cur_q.imm[15]}}, cur_q.imm};
  assign addr = a_q + simm;
  assign off = addr - data_base_q;
  assign k = off[1:0];
  assign is_store = cur_q.op[3];
  assign wsize = (18'(data_bytes_q) < 18'(MemWords * 4)) ? 18'(data_bytes_q)
                                                          : 18'(MemWords * 4);
  assign target = pc_q + 32'd4 + {simm[29:0], 2'b00};

  always_comb begin
    case (cur_q.op)
      OpLb, OpLbu, OpSb: nbytes = 32'd1;
      OpLh, OpLhu, OpSh: nbytes = 32'd2;
      OpLwl: nbytes = 32'd4 - 32'(k);
      OpLwr: nbytes = 32'(k) + 32'd1;
      default: nbytes = 32'd4;
    endcase
  end
  assign start = (cur_q.op == OpLwr) ? {off[31:2], 2'b00} : off;
  assign endb = 33'(start) + 33'(nbytes);
  assign range_bad = (addr < data_base_q) || (endb > 33'(wsize));
  assign w0 = start[MemAw+1:2];
  assign w1 = w0 + MemAw'(1);

  // Bytes from start onward, left-justified.
  assign pair = {rd0_q, rd1_q};
  assign shifted = pair << {start[1:0], 3'b000};

  always_comb begin
    case (nbytes[2:0])
      3'd1: v = {24'd0, shifted[63:56]};
      3'd2: v = {16'd0, shifted[63:48]};
      3'd3: v = {8'd0, shifted[63:40]};
      default: v = shifted[63:32];
    endcase
  end

  // Store: byte lanes across the two-word pair.
  logic [63:0] st_data, st_mask, st_new;
  logic [31:0] bn;
  always_comb begin
    bn = b_q << {(3'd4 - nbytes[2:0]), 3'b000};
    st_data = {bn, 32'd0} >> {start[1:0], 3'b000};
    st_mask = {{32{1'b1}} << {(3'd4 - nbytes[2:0]), 3'b000}, 32'd0}
              >> {start[1:0], 3'b000};
    st_new = (pair & ~st_mask) | (st_data & st_mask);
  end

  // Execute result.
  logic [2:0]  r_status;
  logic [31:0] r_npc, r_val, r_io, s;
  logic        r_wr, take;
  logic [4:0]  r_idx;
  logic [63:0] keep;
  always_comb begin
    r_status = StOk;
    r_wr = 1'b0;
    r_idx = cur_q.rt;
    r_val = 32'd0;
    r_io = 32'd0;
    take = 1'b0;
    s = a_q + simm;
    keep = 64'd0;
    case (cur_q.op)
      OpRegimm: begin
        case (cur_q.rt)
          5'd0: take = a_q[31];
          5'd1: take = !a_q[31];
          5'd16: begin
            take = a_q[31]; r_wr = 1'b1; r_idx = 5'd31; r_val = pc_q + 32'd8;
          end
          5'd17: begin
            take = !a_q[31]; r_wr = 1'b1; r_idx = 5'd31; r_val = pc_q + 32'd8;
          end
          default: r_status = StInvalid;
        endcase
      end
      OpBeq: take = (a_q == b_q);
      OpBne: take = (a_q != b_q);
      OpBlez: if (cur_q.rt != 5'd0) r_status = StInvalid;
              else take = a_q[31] || (a_q == 32'd0);
      OpBgtz: if (cur_q.rt != 5'd0) r_status = StInvalid;
              else take = !a_q[31] && (a_q != 32'd0);
      OpAddi: if (((a_q ^ s) & (simm ^ s) & SignBit) != 32'd0) r_status = StOverflow;
              else begin r_wr = 1'b1; r_val = s; end
      OpAddiu: begin r_wr = 1'b1; r_val = s; end
      OpSlti: begin
        r_wr = 1'b1; r_val = {31'd0, (a_q ^ SignBit) < (simm ^ SignBit)};
      end
      OpSltiu: begin r_wr = 1'b1; r_val = {31'd0, a_q < simm}; end
      OpAndi: begin r_wr = 1'b1; r_val = a_q & {16'd0, cur_q.imm}; end
      OpOri: begin r_wr = 1'b1; r_val = a_q | {16'd0, cur_q.imm}; end
      OpXori: begin r_wr = 1'b1; r_val = a_q ^ {16'd0, cur_q.imm}; end
      OpLui: if (cur_q.rs != 5'd0) r_status = StInvalid;
             else begin r_wr = 1'b1; r_val = {cur_q.imm, 16'd0}; end
      OpLb, OpLh, OpLwl, OpLw, OpLbu, OpLhu, OpLwr, OpSb, OpSh, OpSw: begin
        if (addr == IoAddr) begin
          if (is_store) begin
            r_status = StIoWrite;
            case (cur_q.op)
              OpSb: r_io = {24'd0, b_q[7:0]};
              OpSh: r_io = {16'd0, b_q[15:0]};
              default: r_io = b_q;
            endcase
          end else begin
            r_status = StIoRead;
          end
        end else if (range_bad) begin
          r_status = StRange;
        end else if (!is_store) begin
          r_wr = 1'b1;
          case (cur_q.op)
            OpLb: r_val = {{24{v[7]}}, v[7:0]};
            OpLh: r_val = {{16{v[15]}}, v[15:0]};
            OpLwl: begin
              keep = (64'd1 << {k, 3'b000}) - 64'd1;
              r_val = (v << {k, 3'b000}) | (b_q & keep[31:0]);
            end
            OpLwr: begin
              keep = (64'd1 << {nbytes[2:0], 3'b000}) - 64'd1;
              r_val = v | (b_q & ~keep[31:0]);
            end
            default: r_val = v;
          endcase
        end
      end
      default: r_status = StInvalid;
    endcase
    r_npc = take ? target : pc_q + 32'd4;
    if (r_status >= StInvalid) begin
      r_npc = pc_q; r_wr = 1'b0; r_io = 32'd0;
    end
    if (!r_wr || r_idx == 5'd0) begin
      r_wr = 1'b0; r_idx = 5'd0; r_val = 32'd0;
    end
  end

  logic out_free;
  logic finish;
  assign out_free = !out_valid_q || out_if.ready;
  assign finish = (st_q == BkRead) && out_free;
  assign deq_ready_o = (st_q == BkIdle) && !clearing;

  always_comb begin
    st_d = st_q;
    case (st_q)
      BkIdle: if (deq_valid_i && !clearing) st_d = BkRead;
      BkRead: if (out_free) st_d = BkIdle;
      default: st_d = BkIdle;
    endcase
  end

  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_q;
  assign out_if.status = o_status_q;
  assign out_if.next_pc = o_npc_q;
  assign out_if.reg_written = o_wr_q;
  assign out_if.reg_index = o_idx_q;
  assign out_if.reg_value = o_val_q;
  assign out_if.io_data = o_io_q;

  logic do_store;
  assign do_store = finish && is_store && cur_q.is_mem && r_status == StOk;

  // Memory: pair of reads when a request is taken, write-back on finish. A
  // store rewrites word w0 here and, if it spans into w1, w1 the next cycle
  // via a pending write; a read of that word in the same cycle takes the pending data.
  logic            pend_q;
  logic [MemAw-1:0] pend_addr_q;
  logic [31:0]     pend_data_q;
  logic [MemAw-1:0] ra0, ra1;
  logic [MemAw+1:0] next_start;
  logic [31:0] dec_off;
  assign dec_off = regs_q[deq_i.rs] + {{16{deq_i.imm[15]}}, deq_i.imm} - data_base_q;
  assign next_start = (deq_i.op == OpLwr) ? {dec_off[MemAw+1:2], 2'b00} : dec_off[MemAw+1:0];
  assign ra0 = next_start[MemAw+1:2];
  assign ra1 = ra0 + MemAw'(1);

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      mem_q[clr_cnt_q[MemAw-1:0]] <= 32'd0;
    end else if (do_store) begin
      mem_q[w0] <= st_new[63:32];
    end else if (pend_q) begin
      mem_q[pend_addr_q] <= pend_data_q;
    end
    if (deq_ready_o && deq_valid_i) begin
      rd0_q <= (pend_q && pend_addr_q == ra0) ? pend_data_q : mem_q[ra0];
      rd1_q <= (pend_q && pend_addr_q == ra1) ? pend_data_q : mem_q[ra1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (deq_ready_o && deq_valid_i) begin
      cur_q <= deq_i;
      a_q <= regs_q[deq_i.rs];
      b_q <= regs_q[deq_i.rt];
    end
    if (finish) begin
      o_status_q <= r_status;
      o_npc_q <= r_npc;
      o_wr_q <= r_wr;
      o_idx_q <= r_idx;
      o_val_q <= r_val;
      o_io_q <= r_io;
    end
    pend_addr_q <= w1;
    pend_data_q <= st_new[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BkIdle;
      out_valid_q <= 1'b0;
      pend_q <= 1'b0;
      clr_cnt_q <= '0;
      data_base_q <= 32'h2000_0000;
      data_bytes_q <= 17'd65536;
      pc_q <= 32'h1000_0000;
      for (int i = 0; i < 32; i++) regs_q[i] <= 32'd0;
    end else begin
      st_q <= st_d;
      // The store reaches into the second word when its last byte lies past w0.
      pend_q <= do_store && ((3'(start[1:0]) + nbytes[2:0]) > 3'd4);
      if (clearing) clr_cnt_q <= clr_cnt_q + (MemAw+1)'(1);
      if (cfg_if.valid) begin
        case (cfg_if.index)
          CfgDataBase: data_base_q <= cfg_if.data;
          CfgDataBytes: data_bytes_q <= cfg_if.data[16:0];
          // A boot address write is ignored; reset restores the fixed default PC.
          CfgBootAddr: ;
          default: ;
        endcase
      end
      if (finish) begin
        out_valid_q <= 1'b1;
        pc_q <= r_npc;
        if (r_wr) regs_q[r_idx] <= r_val;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) clearing |-> !deq_ready_o)
    else $error("accepted work during clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni) regs_q[0] == 32'd0)
    else $error("register zero written");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !out_if.ready) |=> $stable(o_npc_q))
    else $error("held result changed");
endmodule
`default_nettype wire

// ===== sv/mips_itype_execute.sv =====
// Top level of the I-type execute block: front queue and back execute unit.
// Depends on mie_pkg, mie_if, mie_front and mie_back.
//
// Each instruction passes through two steps in the back end: the register and
// data memory reads, then execute and write-back. A two-entry queue accepts new
// words meanwhile, and a result register holds a finished result while the next
// one is worked on. After reset the data memory is cleared one word a cycle, all
// 16384 words, and no instruction is executed until that is done; configuration
// writes are taken at any time, and the PC starts from the default boot address
// at reset.
`timescale 1ns / 1ps
`default_nettype none
module mips_itype_execute (
  input  wire           clk_i,
  input  wire           rst_ni,
  mie_instr_if.sink     in_if,
  mie_cfg_if.sink       cfg_if,
  mie_result_if.source  out_if
);
  import mie_pkg::*;

  logic deq_valid, deq_ready;
  dec_t deq;

  mie_front u_front (
    .clk_i, .rst_ni, .in_if,
    .deq_valid_o(deq_valid), .deq_ready_i(deq_ready), .deq_o(deq)
  );

  mie_back u_back (
    .clk_i, .rst_ni,
    .deq_valid_i(deq_valid), .deq_ready_o(deq_ready), .deq_i(deq),
    .cfg_if, .out_if
  );
endmodule
`default_nettype wire

// ===== tb/mips_itype_execute_tb.sv =====
// Self-checking testbench for the MIPS I-type execute block.
// Depends on mie_pkg, mie_if and the mips_itype_execute RTL.
`timescale 1ns / 1ps
module mips_itype_execute_tb;
  import mie_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [31:0] io_data;
  } exec_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mie_instr_if  instr_bus ();
  mie_cfg_if    cfg_bus ();
  mie_result_if result_bus ();

  mips_itype_execute u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (instr_bus.sink),
    .cfg_if(cfg_bus.sink),
    .out_if(result_bus.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Architectural shadow state of the block.
  logic [31:0]  gpr_shadow [32];
  logic [31:0]  dmem_shadow [MemWords];
  logic [31:0]  pc_shadow;
  logic [31:0]  base_shadow;
  logic [16:0]  bytes_shadow;
  exec_result_t pending_results [$];
  int           failures = 0;
  bit           gaps_on = 1'b1;
  bit           stalls_on = 1'b1;
  bit           long_hold = 1'b0;

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] window_bytes();
    return (bytes_shadow < MemWords * 4) ? 32'(bytes_shadow) : MemWords * 4;
  endfunction

  function automatic logic [7:0] byte_at(logic [31:0] off);
    return 8'(dmem_shadow[(off >> 2) % MemWords] >> ((3 - off[1:0]) * 8));
  endfunction

  function automatic void byte_put(logic [31:0] off, logic [7:0] v);
    int unsigned idx;
    int unsigned sh;
    idx = (off >> 2) % MemWords;
    sh = (3 - off[1:0]) * 8;
    dmem_shadow[idx] = (dmem_shadow[idx] & ~(32'hFF << sh)) | (32'(v) << sh);
  endfunction

  // Executes one instruction on the shadow state and returns its result.
  function automatic exec_result_t execute_instr(logic [31:0] w);
    exec_result_t r;
    logic [5:0]  op;
    logic [4:0]  rs, rt;
    logic [15:0] imm;
    logic [31:0] simm, a, b, s, addr, off, start, v;
    logic [63:0] mask;
    int unsigned n, k;
    bit take, link, store;
    op = w[31:26]; rs = w[25:21]; rt = w[20:16]; imm = w[15:0];
    simm = {{16{imm[15]}}, imm};
    a = gpr_shadow[rs]; b = gpr_shadow[rt];
    r = '0;
    r.next_pc = pc_shadow + 4;
    take = 0; link = 0;
    case (op)
      OpRegimm: begin
        if (rt == 0) take = a[31];
        else if (rt == 1) take = !a[31];
        else if (rt == 16) begin take = a[31]; link = 1; end
        else if (rt == 17) begin take = !a[31]; link = 1; end
        else r.status = StInvalid;
      end
      OpBeq: take = (a == b);
      OpBne: take = (a != b);
      OpBlez: if (rt != 0) r.status = StInvalid; else take = a[31] || a == 0;
      OpBgtz: if (rt != 0) r.status = StInvalid; else take = !a[31] && a != 0;
      OpAddi: begin
        s = a + simm;
        if (((a ^ s) & (simm ^ s)) & SignBit) r.status = StOverflow;
        else begin r.reg_written = 1; r.reg_index = rt; r.reg_value = s; end
      end
      OpAddiu: begin r.reg_written = 1; r.reg_index = rt; r.reg_value = a + simm; end
      OpSlti: begin
        r.reg_written = 1; r.reg_index = rt; r.reg_value = 32'($signed(a) < $signed(simm));
      end
      OpSltiu: begin r.reg_written = 1; r.reg_index = rt; r.reg_value = 32'(a < simm); end
      OpAndi: begin r.reg_written = 1; r.reg_index = rt; r.reg_value = a & {16'h0, imm}; end
      OpOri: begin r.reg_written = 1; r.reg_index = rt; r.reg_value = a | {16'h0, imm}; end
      OpXori: begin r.reg_written = 1; r.reg_index = rt; r.reg_value = a ^ {16'h0, imm}; end
      OpLui: begin
        if (rs != 0) r.status = StInvalid;
        else begin r.reg_written = 1; r.reg_index = rt; r.reg_value = {imm, 16'h0}; end
      end
      OpLb, OpLh, OpLwl, OpLw, OpLbu, OpLhu, OpLwr, OpSb, OpSh, OpSw: begin
        addr = a + simm;
        store = (op >= OpSb);
        if (addr == IoAddr) begin
          if (store) begin
            r.status = StIoWrite;
            r.io_data = (op == OpSb) ? (b & 32'hFF) : (op == OpSh) ? (b & 32'hFFFF) : b;
          end else begin
            r.status = StIoRead;
          end
        end else if (addr < base_shadow) begin
          r.status = StRange;
        end else begin
          off = addr - base_shadow;
          k = off[1:0];
          start = off;
          case (op)
            OpLb, OpLbu, OpSb: n = 1;
            OpLh, OpLhu, OpSh: n = 2;
            OpLwl: n = 4 - k;
            OpLwr: begin start = off - k; n = k + 1; end
            default: n = 4;
          endcase
          if (64'(start) + n > 64'(window_bytes())) begin
            r.status = StRange;
          end else if (store) begin
            for (int i = 0; i < n; i++) byte_put(start + i, 8'(b >> ((n - 1 - i) * 8)));
          end else begin
            v = 0;
            for (int i = 0; i < n; i++) v = (v << 8) | byte_at(start + i);
            r.reg_written = 1; r.reg_index = rt;
            case (op)
              OpLb: r.reg_value = {{24{v[7]}}, v[7:0]};
              OpLh: r.reg_value = {{16{v[15]}}, v[15:0]};
              OpLwl: begin
                mask = (64'd1 << (8 * k)) - 1;
                r.reg_value = 32'((64'(v) << (8 * k)) | (64'(b) & mask));
              end
              OpLwr: begin
                mask = (64'd1 << (8 * n)) - 1;
                r.reg_value = 32'(64'(v) | (64'(b) & ~mask));
              end
              default: r.reg_value = v;
            endcase
          end
        end
      end
      default: r.status = StInvalid;
    endcase

    if (r.status >= StInvalid) begin
      r.next_pc = pc_shadow;
      r.reg_written = 0; r.reg_index = 0; r.reg_value = 0; r.io_data = 0;
    end else begin
      if (link) begin r.reg_written = 1; r.reg_index = 31; r.reg_value = pc_shadow + 8; end
      if (take) r.next_pc = pc_shadow + 4 + (simm << 2);
      if (r.reg_written && r.reg_index != 0) gpr_shadow[r.reg_index] = r.reg_value;
      else begin r.reg_written = 0; r.reg_index = 0; r.reg_value = 0; end
      pc_shadow = r.next_pc;
    end
    return r;
  endfunction

  function automatic int unsigned draw_pause(bit enabled);
    if (!enabled || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  // Offers one instruction and records its prediction once it is accepted.
  // Valid is left high so that a following request can go out back to back.
  task automatic send_instr(logic [31:0] w);
    int unsigned gap;
    gap = draw_pause(gaps_on);
    if (gap > 0) begin
      instr_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    instr_bus.valid <= 1'b1;
    instr_bus.instruction_word <= w;
    do @(posedge clk_i); while (!instr_bus.ready);
    pending_results.push_back(execute_instr(w));
  endtask

  task automatic drain();
    instr_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CfgDataBase: base_shadow = value;
      CfgDataBytes: bytes_shadow = value[16:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Memory access at an absolute address through pointer register 1..3;
  // the pointer is reloaded with LUI/ORI when the offset will not reach.
  task automatic access_mem(logic [5:0] op, logic [31:0] addr, logic [4:0] rt);
    logic [4:0]  ptr;
    logic [31:0] diff;
    ptr = 5'($urandom_range(1, 3));
    diff = addr - gpr_shadow[ptr];
    if ($signed(diff) < -32768 || $signed(diff) > 32767) begin
      send_instr(itype(OpLui, 5'd0, ptr, addr[31:16]));
      send_instr(itype(OpOri, ptr, ptr, addr[15:0]));
      diff = 0;
    end
    send_instr(itype(op, ptr, rt, diff[15:0]));
  endtask

  task automatic random_mem_op();
    logic [5:0]  mem_ops [10] = '{OpLb, OpLh, OpLwl, OpLw, OpLbu, OpLhu, OpLwr,
                                  OpSb, OpSh, OpSw};
    logic [31:0] addr;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) addr = base_shadow + $urandom_range(0, 63);
    else if (pick < 17) addr = base_shadow + window_bytes() - 8 + $urandom_range(0, 11);
    else if (pick < 19) addr = base_shadow - $urandom_range(1, 4);
    else addr = IoAddr;
    access_mem(mem_ops[$urandom_range(0, 9)], addr, 5'($urandom_range(0, 31)));
  endtask

  task automatic random_item();
    logic [5:0] alu_ops [8] = '{OpAddi, OpAddiu, OpSlti, OpSltiu, OpAndi, OpOri, OpXori,
                                OpLui};
    logic [5:0] br_ops [5] = '{OpRegimm, OpBeq, OpBne, OpBlez, OpBgtz};
    logic [4:0] rt_pick [6] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd0, 5'd0};
    int unsigned pick;
    logic [5:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      random_mem_op();
    end else if (pick < 70) begin
      op = alu_ops[$urandom_range(0, 7)];
      send_instr(itype(op, (op == OpLui) ? 5'd0 : 5'($urandom_range(0, 31)),
                       5'($urandom_range(4, 31)), 16'($urandom)));
    end else if (pick < 85) begin
      op = br_ops[$urandom_range(0, 4)];
      send_instr(itype(op, 5'($urandom_range(0, 31)),
                       (op == OpBeq || op == OpBne) ? 5'($urandom_range(0, 31)) :
                       rt_pick[$urandom_range(0, 5)], 16'($urandom)));
    end else begin
      send_instr($urandom);
    end
  endtask

  task automatic test_directed();
    logic [5:0] mem_ops [10] = '{OpLb, OpLh, OpLwl, OpLw, OpLbu, OpLhu, OpLwr,
                                OpSb, OpSh, OpSw};
    send_instr(itype(OpLui, 0, 4, 16'h8000));
    send_instr(itype(OpAddi, 4, 5, 16'hFFFF));     // most negative minus one overflows
    send_instr(itype(OpOri, 0, 6, 16'hFFFF));
    send_instr(itype(OpXori, 4, 7, 16'hFFFF));
    send_instr(itype(OpAddi, 7, 8, 16'h0001));     // 0x8000FFFF plus one does not overflow
    send_instr(itype(OpAddiu, 7, 0, 16'h0001));    // write to register zero is dropped
    send_instr(itype(OpSlti, 4, 9, 16'h7FFF));
    send_instr(itype(OpSltiu, 4, 10, 16'h8000));
    send_instr(itype(OpAndi, 7, 11, 16'hFFFF));
    send_instr(itype(OpLui, 1, 12, 16'h1234));     // LUI with nonzero rs is invalid
    send_instr(itype(OpRegimm, 4, 2, 16'h0003));   // unknown REGIMM selector
    send_instr(itype(OpBlez, 0, 1, 16'h0001));     // BLEZ with nonzero rt is invalid
    send_instr(itype(6'h3F, 31, 31, 16'hFFFF));
    send_instr(itype(OpRegimm, 4, 16, 16'h8000));
    send_instr(itype(OpRegimm, 4, 17, 16'h7FFF));
    send_instr(itype(OpRegimm, 7, 0, 16'h0010));
    send_instr(itype(OpRegimm, 7, 1, 16'hFFF0));
    send_instr(itype(OpBeq, 0, 0, 16'h0004));
    send_instr(itype(OpBne, 4, 7, 16'hFFFC));
    send_instr(itype(OpBlez, 0, 0, 16'h0002));
    send_instr(itype(OpBgtz, 7, 0, 16'h0002));
    access_mem(OpSw, base_shadow + 1, 5'd7);        // store spanning two words
    foreach (mem_ops[i]) access_mem(mem_ops[i], base_shadow + i % 4, 5'(4 + i));
    access_mem(OpSb, IoAddr, 5'd6);
    access_mem(OpSh, IoAddr, 5'd6);
    access_mem(OpLw, IoAddr, 5'd6);
    access_mem(OpLw, base_shadow + window_bytes() - 2, 5'd6);
    access_mem(OpLb, base_shadow - 1, 5'd6);
  endtask

  task automatic test_random(int unsigned count);
    repeat (count) random_item();
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    long_hold = 1'b1;
    repeat (30) random_item();
    gaps_on = 1'b1;
  endtask

  task automatic test_config_sweep();
    logic [31:0] bases [5] = '{32'h0, 32'h0, 32'hFFFF_FFF0, 32'h1234_5677, 32'h2000_0000};
    logic [16:0] sizes [5] = '{17'd65536, 17'd0, 17'd16, 17'd17, 17'd65536};
    foreach (bases[i]) begin
      drain();
      write_cfg(CfgDataBase, bases[i]);
      write_cfg(CfgDataBytes, 32'(sizes[i]));
      stalls_on = (i % 2 == 0);
      test_random(230);
    end
    stalls_on = 1'b1;
  endtask

  task automatic test_boot_address();
    drain();
    // The program counter is already running, so these must not move it.
    write_cfg(CfgBootAddr, 32'h0);
    write_cfg(CfgBootAddr, 32'hFFFF_FFFF);
    test_random(40);
  endtask

  // Result receiver with random stalls and one long hold when requested.
  initial begin
    int unsigned stall;
    result_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        result_bus.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        stall = draw_pause(stalls_on);
        if (stall > 0) begin
          result_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!result_bus.valid);
    end
  end

  always @(posedge clk_i) begin
    exec_result_t exp_r;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no instruction outstanding");
        failures++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_bus.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, result_bus.status);
          failures++;
        end
        if (result_bus.next_pc !== exp_r.next_pc) begin
          $error("next_pc: expected %h, got %h", exp_r.next_pc, result_bus.next_pc);
          failures++;
        end
        if (result_bus.reg_written !== exp_r.reg_written) begin
          $error("reg_written: expected %0d, got %0d", exp_r.reg_written,
                 result_bus.reg_written);
          failures++;
        end
        if (result_bus.reg_index !== exp_r.reg_index) begin
          $error("reg_index: expected %0d, got %0d", exp_r.reg_index, result_bus.reg_index);
          failures++;
        end
        if (result_bus.reg_value !== exp_r.reg_value) begin
          $error("reg_value: expected %h, got %h", exp_r.reg_value, result_bus.reg_value);
          failures++;
        end
        if (result_bus.io_data !== exp_r.io_data) begin
          $error("io_data: expected %h, got %h", exp_r.io_data, result_bus.io_data);
          failures++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    instr_bus.valid <= 1'b0;
    instr_bus.instruction_word <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CfgDataBase;
    cfg_bus.data <= '0;
    foreach (gpr_shadow[i]) gpr_shadow[i] = '0;
    foreach (dmem_shadow[i]) dmem_shadow[i] = '0;
    base_shadow = 32'h2000_0000;
    bytes_shadow = 17'd65536;
    pc_shadow = 32'h1000_0000;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(550);
    test_backpressure();
    test_config_sweep();
    test_boot_address();
    drain();
    repeat (20) @(posedge clk_i);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
